>>> hw/rtl/atp_pkg.sv
// Shared types, character codes and limits of the AT command line parser.
`default_nettype none

package atp_pkg;

  // Limits of the command line format.
  localparam int unsigned NAME_LIMIT = 16;
  localparam int unsigned MAX_PARAMS = 16;
  localparam int unsigned INT_DIGITS = 7;

  // Counter widths that follow from the limits.
  localparam int unsigned NL_W = $clog2(NAME_LIMIT);
  localparam int unsigned PT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned DC_W = $clog2(INT_DIGITS + 1);

  localparam int unsigned ACC_W = 24;
  localparam int unsigned IDX_W = 4;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  // Parser states.
  typedef enum logic [3:0] {
    ST_INIT       = 4'd0,
    ST_GOT_A      = 4'd1,
    ST_GOT_T      = 4'd2,
    ST_NAME       = 4'd3,
    ST_PARAM      = 4'd4,
    ST_STRING     = 4'd5,
    ST_STRING_END = 4'd6,
    ST_INT        = 4'd7,
    ST_IDLE       = 4'd8
  } atp_state_e;

  // Verdict codes of a result.
  typedef enum logic [1:0] {
    V_BUSY  = 2'd0,
    V_DONE  = 2'd1,
    V_ERROR = 2'd2,
    V_IDLE  = 2'd3
  } atp_verdict_e;

  // Input request payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_command;
  } atp_in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]       verdict;
    logic             name_char_valid;
    logic             param_start;
    logic             param_type;
    logic [IDX_W-1:0] param_index;
    logic             string_char_valid;
    logic             int_done;
    logic [ACC_W-1:0] int_value;
  } atp_out_t;

  // Parser context carried from one byte to the next.
  typedef struct packed {
    atp_state_e       parse_state;
    logic [NL_W-1:0]  name_length;
    logic [PT_W-1:0]  param_total;
    logic             last_type;
    logic [DC_W-1:0]  digit_count;
    logic [ACC_W-1:0] int_accumulator;
  } atp_ctx_t;

  localparam atp_ctx_t CTX_CLEAR = '{
    parse_state:     ST_INIT,
    name_length:     '0,
    param_total:     '0,
    last_type:       1'b0,
    digit_count:     '0,
    int_accumulator: '0
  };

endpackage

`default_nettype wire

>>> hw/rtl/atp_step.sv
// Combinational parse of one byte against the current parser context.
`default_nettype none

module atp_step (
  input  atp_pkg::atp_in_t  req_i,
  input  atp_pkg::atp_ctx_t ctx_i,
  output atp_pkg::atp_ctx_t ctx_o,
  output atp_pkg::atp_out_t rsp_o
);
  import atp_pkg::*;

  localparam logic [NL_W-1:0] NAME_ERR_AT = NL_W'(NAME_LIMIT - 1);
  localparam logic [PT_W-1:0] PARAM_FULL  = PT_W'(MAX_PARAMS);
  localparam logic [DC_W-1:0] DIGIT_FULL  = DC_W'(INT_DIGITS);

  atp_ctx_t         cur;
  atp_ctx_t         nxt;
  logic [7:0]       c;
  logic             is_digit;
  logic             is_term;
  logic             is_letter;
  logic [3:0]       digit;
  logic [ACC_W-1:0] acc_step;
  logic [ACC_W-1:0] acc_first;
  logic [NL_W-1:0]  nl_inc;
  logic [PT_W-1:0]  pt_inc;
  logic [PT_W-1:0]  idx_full;
  atp_verdict_e     verdict;
  logic             name_ok;
  logic             pstart;
  logic             str_ok;
  logic             idone;
  logic [ACC_W-1:0] ival;

  // A restart drops the command in progress.
  assign cur = req_i.start_of_command ? CTX_CLEAR : ctx_i;

  // Character classes and the decimal step acc * 10 + digit.
  assign c         = req_i.data_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_term   = (c == CH_CR) || (c == CH_NUL);
  assign is_letter = (c >= CH_A) && (c <= CH_Z);
  assign digit     = 4'(c - CH_ZERO);
  assign acc_step  = (cur.int_accumulator << 3) + (cur.int_accumulator << 1)
                   + ACC_W'(digit);
  assign acc_first = ACC_W'(digit);
  assign nl_inc    = cur.name_length + 1'b1;
  assign pt_inc    = cur.param_total + 1'b1;

  // State transitions and per-byte flags.
  always_comb begin
    nxt     = cur;
    verdict = V_BUSY;
    name_ok = 1'b0;
    pstart  = 1'b0;
    str_ok  = 1'b0;
    idone   = 1'b0;
    ival    = '0;
    unique case (cur.parse_state)
      ST_INIT: begin
        if (c == CH_A) nxt.parse_state = ST_GOT_A;
        else if (c == CH_PLUS) nxt.parse_state = ST_NAME;
        else verdict = V_ERROR;
      end
      ST_GOT_A: begin
        if (c == CH_T) nxt.parse_state = ST_GOT_T;
        else verdict = V_ERROR;
      end
      ST_GOT_T: begin
        if (c == CH_PLUS) nxt.parse_state = ST_NAME;
        else verdict = V_ERROR;
      end
      ST_NAME: begin
        if (is_letter) begin
          nxt.name_length = nl_inc;
          if (nl_inc >= NAME_ERR_AT) verdict = V_ERROR;
          else name_ok = 1'b1;
        end else if (c == CH_EQ) begin
          nxt.parse_state = ST_PARAM;
        end else if (is_term) begin
          verdict = V_DONE;
        end else begin
          verdict = V_ERROR;
        end
      end
      ST_PARAM: begin
        if (((c == CH_QUOTE) || is_digit) && (cur.param_total >= PARAM_FULL)) begin
          verdict = V_ERROR;
        end else if (c == CH_QUOTE) begin
          nxt.param_total = pt_inc;
          nxt.last_type   = 1'b1;
          pstart          = 1'b1;
          nxt.parse_state = ST_STRING;
        end else if (is_digit) begin
          nxt.param_total     = pt_inc;
          nxt.last_type       = 1'b0;
          pstart              = 1'b1;
          nxt.digit_count     = DC_W'(1);
          nxt.int_accumulator = acc_first;
          nxt.parse_state     = ST_INT;
        end else begin
          verdict = V_ERROR;
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) nxt.parse_state = ST_STRING_END;
        else if (c == CH_NUL) verdict = V_ERROR;
        else str_ok = 1'b1;
      end
      ST_STRING_END: begin
        if (c == CH_COMMA) nxt.parse_state = ST_PARAM;
        else if (is_term) verdict = V_DONE;
        else verdict = V_ERROR;
      end
      ST_INT: begin
        if ((c == CH_COMMA) || is_term) begin
          idone = 1'b1;
          ival  = cur.int_accumulator;
          if (c == CH_COMMA) nxt.parse_state = ST_PARAM;
          else verdict = V_DONE;
        end else if (is_digit) begin
          // Digits past the limit are accepted but ignored.
          if (cur.digit_count < DIGIT_FULL) begin
            nxt.int_accumulator = acc_step;
            nxt.digit_count     = cur.digit_count + 1'b1;
          end
        end else begin
          verdict = V_ERROR;
        end
      end
      default: begin
        verdict = V_IDLE;
      end
    endcase
    if ((verdict == V_DONE) || (verdict == V_ERROR)) nxt.parse_state = ST_IDLE;
  end

  assign ctx_o    = nxt;
  assign idx_full = nxt.param_total - 1'b1;

  // Result fields; parameter type and index read zero before any parameter.
  always_comb begin
    rsp_o                   = '0;
    rsp_o.verdict           = verdict;
    rsp_o.name_char_valid   = name_ok;
    rsp_o.param_start       = pstart;
    rsp_o.string_char_valid = str_ok;
    rsp_o.int_done          = idone;
    rsp_o.int_value         = ival;
    if ((verdict != V_IDLE) && (nxt.param_total != '0)) begin
      rsp_o.param_type  = nxt.last_type;
      rsp_o.param_index = IDX_W'(idx_full);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/at_command_line_parser_top.sv
// Top level of the AT command line parser: input register, context and result register.
// Path: a byte waits in the input register, is parsed against the fed-back context and
// its result is written to the result register, which drives out_valid_o.
// Throughput: one byte per cycle while out_ready_i does not stall the result register.
// Reset: rst_ni clears both stages and sets the parser to wait for 'A' or '+'.
`default_nettype none

module at_command_line_parser_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  atp_pkg::atp_in_t   in_req_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output atp_pkg::atp_out_t  out_rsp_o
);
  import atp_pkg::*;

  logic     in_valid_q;
  atp_in_t  in_q;
  atp_ctx_t ctx_q;
  atp_ctx_t ctx_d;
  logic     out_valid_q;
  atp_out_t out_q;
  atp_out_t step_rsp;
  logic     step_go;

  // A buffered request moves on when the result register is free or draining.
  assign step_go    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  atp_step u_step (
    .req_i (in_q),
    .ctx_i (ctx_q),
    .ctx_o (ctx_d),
    .rsp_o (step_rsp)
  );

  // Parser context advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CTX_CLEAR;
    end else if (step_go) begin
      ctx_q <= ctx_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A finished or failed command leaves the parser idle.
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && (step_rsp.verdict == V_DONE || step_rsp.verdict == V_ERROR)
    |=> ctx_q.parse_state == ST_IDLE)
    else $error("parser not idle after end of command");

  // An idle verdict carries no flags.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.verdict == V_IDLE)
    |-> !out_q.name_char_valid && !out_q.param_start && !out_q.string_char_valid
        && !out_q.int_done && (out_q.param_index == '0))
    else $error("idle result carries flags");

  // An ended integer never comes with an error or idle verdict.
  a_int_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.int_done
    |-> (out_q.verdict == V_BUSY) || (out_q.verdict == V_DONE))
    else $error("integer ended on a failing byte");

  // The parameter count never passes its limit.
  a_param_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.param_total <= PT_W'(MAX_PARAMS))
    else $error("parameter count past limit");

  // Without a stall, a processed request is offered the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_valid_q)
    else $error("result lost after processing");

endmodule

`default_nettype wire
